FILE: rtl/rgbpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbpb_pkg;

  typedef enum logic [2:0] {
    OP_MULTIPLY = 3'd0,
    OP_SUBTRACT = 3'd1,
    OP_SCREEN   = 3'd2,
    OP_OVERLAY  = 3'd3,
    OP_ADD      = 3'd4,
    OP_SCALE    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_GAIN_BLUE    = 3'd0,
    REG_GAIN_GREEN   = 3'd1,
    REG_GAIN_RED     = 3'd2,
    REG_OFFSET_BLUE  = 3'd3,
    REG_OFFSET_GREEN = 3'd4,
    REG_OFFSET_RED   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_DIV   = 2'd0,
    KIND_PASS  = 2'd1,
    KIND_SCALE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] gain_blue;
    logic [7:0] gain_green;
    logic [7:0] gain_red;
    logic [7:0] offset_blue;
    logic [7:0] offset_green;
    logic [7:0] offset_red;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  localparam logic [7:0]  GAIN_RESET   = 8'd1;
  localparam logic [7:0]  OFFSET_RESET = 8'd0;
  localparam logic [17:0] ROUND_BIAS   = 18'd127;
  localparam logic [18:0] RECIP_255    = 19'd263173;
  localparam int          RECIP_SHIFT  = 26;

endpackage

`default_nettype wire

FILE: rtl/rgbpb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbpb_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output rgbpb_pkg::cfg_t        cfg
);
  import rgbpb_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_blue    <= GAIN_RESET;
      cfg.gain_green   <= GAIN_RESET;
      cfg.gain_red     <= GAIN_RESET;
      cfg.offset_blue  <= OFFSET_RESET;
      cfg.offset_green <= OFFSET_RESET;
      cfg.offset_red   <= OFFSET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_BLUE:    cfg.gain_blue    <= cfg_data;
        REG_GAIN_GREEN:   cfg.gain_green   <= cfg_data;
        REG_GAIN_RED:     cfg.gain_red     <= cfg_data;
        REG_OFFSET_BLUE:  cfg.offset_blue  <= cfg_data;
        REG_OFFSET_GREEN: cfg.offset_green <= cfg_data;
        REG_OFFSET_RED:   cfg.offset_red   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgbpb_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbpb_chan (
  input  wire logic                 clk,
  input  wire rgbpb_pkg::stage_en_t en,
  input  wire rgbpb_pkg::op_t       op,
  input  wire logic [7:0]           a,
  input  wire logic [7:0]           b,
  input  wire logic [7:0]           gain,
  input  wire logic [7:0]           offset,
  output logic [7:0]                res
);
  import rgbpb_pkg::*;

  kind_t              kind_next;
  logic               dbl_next;
  logic               inv_next;
  logic [7:0]         x_next;
  logic [7:0]         y_next;
  logic [7:0]         direct_next;
  logic [8:0]         sum;

  kind_t              r1_kind;
  logic               r1_dbl;
  logic               r1_inv;
  logic [7:0]         r1_direct;
  logic signed [8:0]  r1_xs;
  logic signed [8:0]  r1_ys;

  kind_t              r2_kind;
  logic               r2_dbl;
  logic               r2_inv;
  logic [7:0]         r2_direct;
  logic signed [17:0] r2_prod;

  logic [17:0]        dividend;

  kind_t              r3_kind;
  logic               r3_inv;
  logic [7:0]         r3_direct;
  logic signed [17:0] r3_prod;
  logic [36:0]        r3_mul;

  logic [7:0]         quot;
  logic [7:0]         res_next;

  assign sum = {1'b0, a} + {1'b0, offset};

  always_comb begin
    kind_next   = KIND_PASS;
    dbl_next    = 1'b0;
    inv_next    = 1'b0;
    x_next      = a;
    y_next      = b;
    direct_next = 8'd0;
    case (op)
      OP_MULTIPLY: kind_next = KIND_DIV;
      OP_SUBTRACT: direct_next = (b > a) ? (b - a) : 8'd0;
      OP_SCREEN: begin
        kind_next = KIND_DIV;
        inv_next  = 1'b1;
        x_next    = ~a;
        y_next    = ~b;
      end
      OP_OVERLAY: begin
        kind_next = KIND_DIV;
        dbl_next  = 1'b1;
        if (b[7]) begin
          inv_next = 1'b1;
          x_next   = ~a;
          y_next   = ~b;
        end
      end
      OP_ADD:   direct_next = sum[8] ? 8'hFF : sum[7:0];
      OP_SCALE: kind_next = KIND_SCALE;
      default:  direct_next = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      r1_kind   <= kind_next;
      r1_dbl    <= dbl_next;
      r1_inv    <= inv_next;
      r1_direct <= direct_next;
      r1_xs     <= $signed({1'b0, x_next});
      r1_ys     <= (kind_next == KIND_SCALE) ? $signed({gain[7], gain})
                                             : $signed({1'b0, y_next});
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      r2_kind   <= r1_kind;
      r2_dbl    <= r1_dbl;
      r2_inv    <= r1_inv;
      r2_direct <= r1_direct;
      r2_prod   <= r1_xs * r1_ys;
    end
  end

  // round to nearest: floor((p + 127) / 255) by reciprocal multiply
  assign dividend = (r2_dbl ? {1'b0, r2_prod[15:0], 1'b0} : {2'b00, r2_prod[15:0]})
                    + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      r3_kind   <= r2_kind;
      r3_inv    <= r2_inv;
      r3_direct <= r2_direct;
      r3_prod   <= r2_prod;
      r3_mul    <= {19'd0, dividend} * {18'd0, RECIP_255};
    end
  end

  assign quot = r3_mul[RECIP_SHIFT +: 8];

  always_comb begin
    case (r3_kind)
      KIND_DIV:   res_next = r3_inv ? (8'hFF - quot) : quot;
      KIND_SCALE: begin
        if (r3_prod[17]) begin
          res_next = 8'd0;
        end else if (|r3_prod[16:8]) begin
          res_next = 8'hFF;
        end else begin
          res_next = r3_prod[7:0];
        end
      end
      default:    res_next = r3_direct;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rgb_pixel_blend_unit_core.sv
// One request per cycle unless m_axis_tready stalls a valid output; stages are operand prep,
// 9x9 product, reciprocal multiply for the divide by 255, then finish and output register.
// Reset (rst, synchronous): clears all stage valid bits, gains to 1, offsets to 0.
`timescale 1ns / 1ps
`default_nettype none

module rgb_pixel_blend_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // op[2:0], a_blue[10:3], a_green[18:11], a_red[26:19],
  // b_blue[34:27], b_green[42:35], b_red[50:43], zero pad [55:51]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_blue[7:0], out_green[15:8], out_red[23:16]
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import rgbpb_pkg::*;

  cfg_t      cfg;
  stage_en_t en;
  op_t       op;
  logic      v1;
  logic      v2;
  logic      v3;
  logic      v4;

  rgbpb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign en.s4 = !v4 || m_axis_tready;
  assign en.s3 = !v3 || en.s4;
  assign en.s2 = !v2 || en.s3;
  assign en.s1 = !v1 || en.s2;

  assign s_axis_tready = en.s1;
  assign m_axis_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.s1) v1 <= s_axis_tvalid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
    end
  end

  assign op = op_t'(s_axis_tdata[2:0]);

  rgbpb_chan u_blue (
    .clk    (clk),
    .en     (en),
    .op     (op),
    .a      (s_axis_tdata[10:3]),
    .b      (s_axis_tdata[34:27]),
    .gain   (cfg.gain_blue),
    .offset (cfg.offset_blue),
    .res    (m_axis_tdata[7:0])
  );

  rgbpb_chan u_green (
    .clk    (clk),
    .en     (en),
    .op     (op),
    .a      (s_axis_tdata[18:11]),
    .b      (s_axis_tdata[42:35]),
    .gain   (cfg.gain_green),
    .offset (cfg.offset_green),
    .res    (m_axis_tdata[15:8])
  );

  rgbpb_chan u_red (
    .clk    (clk),
    .en     (en),
    .op     (op),
    .a      (s_axis_tdata[26:19]),
    .b      (s_axis_tdata[50:43]),
    .gain   (cfg.gain_red),
    .offset (cfg.offset_red),
    .res    (m_axis_tdata[23:16])
  );

endmodule

`default_nettype wire
